[design/ubh_pkg.sv]
`timescale 1ns / 1ps

package ubh_pkg;

    // Image limits
    localparam int BLOCK_BYTES = 256;
    localparam int MAX_IMAGE   = 524288;
    localparam logic [8:0]  BLOCK_LEN = 9'(BLOCK_BYTES);
    localparam logic [19:0] MAX_LEN   = 20'(MAX_IMAGE);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_IMAGE   = 2'd1;
    localparam logic [1:0] KIND_RX      = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    // Operations
    localparam logic [2:0] OP_SYNC      = 3'd0;
    localparam logic [2:0] OP_ERASE     = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_GO        = 3'd3;
    localparam logic [2:0] OP_UNPROTECT = 3'd4;

    // Final status codes
    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_NO_SYNC        = 4'd1;
    localparam logic [3:0] ST_ERASE_REFUSED  = 4'd2;
    localparam logic [3:0] ST_ERASE_ALL_REF  = 4'd3;
    localparam logic [3:0] ST_WRITE_REFUSED  = 4'd4;
    localparam logic [3:0] ST_ADDR_REFUSED   = 4'd5;
    localparam logic [3:0] ST_DATA_REFUSED   = 4'd6;
    localparam logic [3:0] ST_GO_REFUSED     = 4'd7;
    localparam logic [3:0] ST_UNP_NO_ANSWER  = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_ACK       = 3'd0;
    localparam logic [2:0] REG_NACK      = 3'd1;
    localparam logic [2:0] REG_SYNC      = 3'd2;
    localparam logic [2:0] REG_WRITE     = 3'd3;
    localparam logic [2:0] REG_ERASE     = 3'd4;
    localparam logic [2:0] REG_ERASE_ALL = 3'd5;
    localparam logic [2:0] REG_GO        = 3'd6;
    localparam logic [2:0] REG_UNPROTECT = 3'd7;

    typedef struct packed {
        logic [7:0] ack_code;
        logic [7:0] nack_code;
        logic [7:0] sync_code;
        logic [7:0] write_command;
        logic [7:0] erase_command;
        logic [7:0] erase_all_code;
        logic [7:0] go_command;
        logic [7:0] unprotect_command;
    } cfg_t;

    // Sequencer phases, one-hot
    typedef enum logic [11:0] {
        PH_IDLE       = 12'b0000_0000_0001,
        PH_SYNC_WAIT  = 12'b0000_0000_0010,
        PH_ERASE_CMD  = 12'b0000_0000_0100,
        PH_ERASE_ALL  = 12'b0000_0000_1000,
        PH_WR_CMD     = 12'b0000_0001_0000,
        PH_WR_ADDR    = 12'b0000_0010_0000,
        PH_WR_DATA    = 12'b0000_0100_0000,
        PH_WR_CHECK   = 12'b0000_1000_0000,
        PH_GO_CMD     = 12'b0001_0000_0000,
        PH_GO_ADDR    = 12'b0010_0000_0000,
        PH_UNP_FIRST  = 12'b0100_0000_0000,
        PH_UNP_SECOND = 12'b1000_0000_0000
    } phase_t;

    // Output burst shapes
    typedef enum logic [1:0] {
        DM_ONE  = 2'd0,   // one byte
        DM_TWO  = 2'd1,   // two bytes
        DM_ADDR = 2'd2,   // four address bytes and their XOR
        DM_FIN  = 2'd3    // status result
    } desc_mode_t;

    typedef struct packed {
        desc_mode_t  mode;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [31:0] addr;
        logic [3:0]  status;
    } desc_t;

endpackage

[design/ubh_queue.sv]
`timescale 1ns / 1ps

module ubh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ubh_pkg::desc_t push_desc,
    input  logic           pop,
    output ubh_pkg::desc_t head_desc,
    output logic           empty,
    output logic           full
);

    ubh_pkg::desc_t                 entry_reg [ubh_pkg::QUEUE_DEPTH];
    logic [ubh_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ubh_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ubh_pkg::QPTR_W:0]       count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (ubh_pkg::QPTR_W + 1)'(ubh_pkg::QUEUE_DEPTH));
    assign head_desc = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[design/ubh_front.sv]
`timescale 1ns / 1ps

module ubh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  ubh_pkg::cfg_t  cfg,
    input  logic           in_valid,
    input  logic [1:0]     kind,
    input  logic [2:0]     operation,
    input  logic [31:0]    start_address,
    input  logic [23:0]    image_length,
    input  logic [7:0]     payload_byte,
    input  logic           queue_full,
    output logic           push,
    output ubh_pkg::desc_t push_desc
);

    ubh_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     target_address_reg, target_address_next;
    logic [19:0]     bytes_remaining_reg, bytes_remaining_next;
    logic [8:0]      block_bytes_left_reg, block_bytes_left_next;
    logic [8:0]      block_length_reg, block_length_next;
    logic [7:0]      running_check_reg, running_check_next;
    logic            sync_retried_reg, sync_retried_next;

    logic            accept;
    logic            is_ack;
    logic            is_nack;

    assign accept  = in_valid && !queue_full;
    assign is_ack  = (kind == ubh_pkg::KIND_RX) && (payload_byte == cfg.ack_code);
    assign is_nack = (kind == ubh_pkg::KIND_RX) && (payload_byte == cfg.nack_code);

    // Classify the item, step the sequencer and build the output burst
    always_comb
    begin
        logic [19:0] len_clamped;
        logic [8:0]  blk;
        logic [8:0]  blk_m1;
        logic [8:0]  left;
        logic [7:0]  chk;
        logic [19:0] rem;

        phase_next            = phase_reg;
        target_address_next   = target_address_reg;
        bytes_remaining_next  = bytes_remaining_reg;
        block_bytes_left_next = block_bytes_left_reg;
        block_length_next     = block_length_reg;
        running_check_next    = running_check_reg;
        sync_retried_next     = sync_retried_reg;
        push                  = 1'b0;
        push_desc.mode        = ubh_pkg::DM_ONE;
        push_desc.byte_a      = '0;
        push_desc.byte_b      = '0;
        push_desc.addr        = target_address_reg;
        push_desc.status      = ubh_pkg::ST_OK;

        len_clamped = (image_length > {4'b0, ubh_pkg::MAX_LEN}) ? ubh_pkg::MAX_LEN
                                                                : image_length[19:0];
        blk = (bytes_remaining_reg > {11'b0, ubh_pkg::BLOCK_LEN}) ? ubh_pkg::BLOCK_LEN
                                                                   : bytes_remaining_reg[8:0];
        if (blk == '0)
        begin
            blk = 9'd1;
        end
        blk_m1 = blk - 9'd1;
        left   = (block_bytes_left_reg != '0) ? block_bytes_left_reg - 9'd1
                                              : block_bytes_left_reg;
        chk    = running_check_reg ^ payload_byte;
        rem    = (bytes_remaining_reg >= {11'b0, block_length_reg})
                 ? bytes_remaining_reg - {11'b0, block_length_reg} : '0;

        if (accept)
        begin
            unique case (kind)
                ubh_pkg::KIND_START:
                begin
                    if (operation <= ubh_pkg::OP_UNPROTECT)
                    begin
                        sync_retried_next     = 1'b0;
                        running_check_next    = '0;
                        block_bytes_left_next = '0;
                        block_length_next     = '0;
                        push                  = 1'b1;
                        unique case (operation)
                            ubh_pkg::OP_SYNC:
                            begin
                                push_desc.byte_a = cfg.sync_code;
                                phase_next       = ubh_pkg::PH_SYNC_WAIT;
                            end
                            ubh_pkg::OP_ERASE:
                            begin
                                push_desc.mode   = ubh_pkg::DM_TWO;
                                push_desc.byte_a = cfg.erase_command;
                                push_desc.byte_b = ~cfg.erase_command;
                                phase_next       = ubh_pkg::PH_ERASE_CMD;
                            end
                            ubh_pkg::OP_WRITE:
                            begin
                                target_address_next  = start_address;
                                bytes_remaining_next = len_clamped;
                                if (len_clamped == '0)
                                begin
                                    push_desc.mode = ubh_pkg::DM_FIN;
                                    phase_next     = ubh_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    push_desc.mode   = ubh_pkg::DM_TWO;
                                    push_desc.byte_a = cfg.write_command;
                                    push_desc.byte_b = ~cfg.write_command;
                                    phase_next       = ubh_pkg::PH_WR_CMD;
                                end
                            end
                            ubh_pkg::OP_GO:
                            begin
                                target_address_next = start_address;
                                push_desc.mode      = ubh_pkg::DM_TWO;
                                push_desc.byte_a    = cfg.go_command;
                                push_desc.byte_b    = ~cfg.go_command;
                                phase_next          = ubh_pkg::PH_GO_CMD;
                            end
                            default:
                            begin
                                push_desc.mode   = ubh_pkg::DM_TWO;
                                push_desc.byte_a = cfg.unprotect_command;
                                push_desc.byte_b = ~cfg.unprotect_command;
                                phase_next       = ubh_pkg::PH_UNP_FIRST;
                            end
                        endcase
                    end
                end
                ubh_pkg::KIND_IMAGE:
                begin
                    if (phase_reg == ubh_pkg::PH_WR_DATA)
                    begin
                        push                  = 1'b1;
                        running_check_next    = chk;
                        block_bytes_left_next = left;
                        push_desc.byte_a      = payload_byte;
                        if (left == '0)
                        begin
                            push_desc.mode   = ubh_pkg::DM_TWO;
                            push_desc.byte_b = chk;
                            phase_next       = ubh_pkg::PH_WR_CHECK;
                        end
                    end
                end
                default:
                begin
                    // Received byte or timeout
                    unique case (phase_reg)
                        ubh_pkg::PH_SYNC_WAIT:
                        begin
                            push = 1'b1;
                            if (is_ack)
                            begin
                                push_desc.mode = ubh_pkg::DM_FIN;
                                phase_next     = ubh_pkg::PH_IDLE;
                            end
                            else if (!sync_retried_reg)
                            begin
                                sync_retried_next = 1'b1;
                                push_desc.byte_a  = cfg.sync_code;
                            end
                            else
                            begin
                                push_desc.mode   = ubh_pkg::DM_FIN;
                                push_desc.status = is_nack ? ubh_pkg::ST_OK
                                                           : ubh_pkg::ST_NO_SYNC;
                                phase_next       = ubh_pkg::PH_IDLE;
                            end
                        end
                        ubh_pkg::PH_ERASE_CMD:
                        begin
                            push = 1'b1;
                            if (is_ack)
                            begin
                                push_desc.mode   = ubh_pkg::DM_TWO;
                                push_desc.byte_a = cfg.erase_all_code;
                                push_desc.byte_b = ~cfg.erase_all_code;
                                phase_next       = ubh_pkg::PH_ERASE_ALL;
                            end
                            else
                            begin
                                push_desc.mode   = ubh_pkg::DM_FIN;
                                push_desc.status = ubh_pkg::ST_ERASE_REFUSED;
                                phase_next       = ubh_pkg::PH_IDLE;
                            end
                        end
                        ubh_pkg::PH_ERASE_ALL:
                        begin
                            push             = 1'b1;
                            push_desc.mode   = ubh_pkg::DM_FIN;
                            push_desc.status = is_ack ? ubh_pkg::ST_OK
                                                      : ubh_pkg::ST_ERASE_ALL_REF;
                            phase_next       = ubh_pkg::PH_IDLE;
                        end
                        ubh_pkg::PH_WR_CMD:
                        begin
                            push = 1'b1;
                            if (is_ack)
                            begin
                                push_desc.mode = ubh_pkg::DM_ADDR;
                                phase_next     = ubh_pkg::PH_WR_ADDR;
                            end
                            else
                            begin
                                push_desc.mode   = ubh_pkg::DM_FIN;
                                push_desc.status = ubh_pkg::ST_WRITE_REFUSED;
                                phase_next       = ubh_pkg::PH_IDLE;
                            end
                        end
                        ubh_pkg::PH_WR_ADDR:
                        begin
                            push = 1'b1;
                            if (is_ack)
                            begin
                                block_length_next     = blk;
                                block_bytes_left_next = blk;
                                running_check_next    = blk_m1[7:0];
                                push_desc.byte_a      = blk_m1[7:0];
                                phase_next            = ubh_pkg::PH_WR_DATA;
                            end
                            else
                            begin
                                push_desc.mode   = ubh_pkg::DM_FIN;
                                push_desc.status = ubh_pkg::ST_ADDR_REFUSED;
                                phase_next       = ubh_pkg::PH_IDLE;
                            end
                        end
                        ubh_pkg::PH_WR_CHECK:
                        begin
                            push = 1'b1;
                            if (is_ack)
                            begin
                                bytes_remaining_next = rem;
                                target_address_next  = target_address_reg
                                                       + {23'b0, block_length_reg};
                                if (rem == '0)
                                begin
                                    push_desc.mode = ubh_pkg::DM_FIN;
                                    phase_next     = ubh_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    push_desc.mode   = ubh_pkg::DM_TWO;
                                    push_desc.byte_a = cfg.write_command;
                                    push_desc.byte_b = ~cfg.write_command;
                                    phase_next       = ubh_pkg::PH_WR_CMD;
                                end
                            end
                            else
                            begin
                                push_desc.mode   = ubh_pkg::DM_FIN;
                                push_desc.status = ubh_pkg::ST_DATA_REFUSED;
                                phase_next       = ubh_pkg::PH_IDLE;
                            end
                        end
                        ubh_pkg::PH_GO_CMD:
                        begin
                            push = 1'b1;
                            if (is_ack)
                            begin
                                push_desc.mode = ubh_pkg::DM_ADDR;
                                phase_next     = ubh_pkg::PH_GO_ADDR;
                            end
                            else
                            begin
                                push_desc.mode   = ubh_pkg::DM_FIN;
                                push_desc.status = ubh_pkg::ST_GO_REFUSED;
                                phase_next       = ubh_pkg::PH_IDLE;
                            end
                        end
                        ubh_pkg::PH_GO_ADDR:
                        begin
                            push             = 1'b1;
                            push_desc.mode   = ubh_pkg::DM_FIN;
                            push_desc.status = is_ack ? ubh_pkg::ST_OK
                                                      : ubh_pkg::ST_GO_REFUSED;
                            phase_next       = ubh_pkg::PH_IDLE;
                        end
                        ubh_pkg::PH_UNP_FIRST:
                        begin
                            // Drop the first answer
                            phase_next = ubh_pkg::PH_UNP_SECOND;
                        end
                        ubh_pkg::PH_UNP_SECOND:
                        begin
                            push             = 1'b1;
                            push_desc.mode   = ubh_pkg::DM_FIN;
                            push_desc.status = (is_ack || is_nack) ? ubh_pkg::ST_OK
                                                                   : ubh_pkg::ST_UNP_NO_ANSWER;
                            phase_next       = ubh_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            // Idle or data phase: nothing awaited
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= ubh_pkg::PH_IDLE;
            target_address_reg   <= '0;
            bytes_remaining_reg  <= '0;
            block_bytes_left_reg <= '0;
            block_length_reg     <= '0;
            running_check_reg    <= '0;
            sync_retried_reg     <= 1'b0;
        end
        else
        begin
            phase_reg            <= phase_next;
            target_address_reg   <= target_address_next;
            bytes_remaining_reg  <= bytes_remaining_next;
            block_bytes_left_reg <= block_bytes_left_next;
            block_length_reg     <= block_length_next;
            running_check_reg    <= running_check_next;
            sync_retried_reg     <= sync_retried_next;
        end
    end

endmodule

[design/ubh_back.sv]
`timescale 1ns / 1ps

module ubh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ubh_pkg::desc_t head_desc,
    input  logic           queue_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     tx_byte,
    output logic           tx_valid,
    output logic           finished,
    output logic [3:0]     status,
    output logic           last
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       tx_valid_reg, tx_valid_next;
    logic       finished_reg, finished_next;
    logic [3:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;

    assign load      = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_valid  = tx_valid_reg;
    assign finished  = finished_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Expand the head entry into one result per cycle unless the output is stalled
    always_comb
    begin
        logic [7:0] addr_xor;

        addr_xor = head_desc.addr[31:24] ^ head_desc.addr[23:16]
                 ^ head_desc.addr[15:8]  ^ head_desc.addr[7:0];

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        tx_valid_next  = tx_valid_reg;
        finished_next  = finished_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = !queue_empty;
            tx_byte_next   = '0;
            tx_valid_next  = 1'b1;
            finished_next  = 1'b0;
            status_next    = ubh_pkg::ST_OK;
            last_next      = 1'b0;
            unique case (head_desc.mode)
                ubh_pkg::DM_ONE:
                begin
                    tx_byte_next = head_desc.byte_a;
                    last_next    = 1'b1;
                end
                ubh_pkg::DM_TWO:
                begin
                    tx_byte_next = (idx_reg == 3'd0) ? head_desc.byte_a : head_desc.byte_b;
                    last_next    = (idx_reg != 3'd0);
                end
                ubh_pkg::DM_ADDR:
                begin
                    unique case (idx_reg)
                        3'd0:    tx_byte_next = head_desc.addr[31:24];
                        3'd1:    tx_byte_next = head_desc.addr[23:16];
                        3'd2:    tx_byte_next = head_desc.addr[15:8];
                        3'd3:    tx_byte_next = head_desc.addr[7:0];
                        default: tx_byte_next = addr_xor;
                    endcase
                    last_next = (idx_reg >= 3'd4);
                end
                default:
                begin
                    tx_valid_next = 1'b0;
                    finished_next = 1'b1;
                    status_next   = head_desc.status;
                    last_next     = 1'b1;
                end
            endcase

            // Advance within the entry, drop it after its last result
            if (!queue_empty)
            begin
                if (last_next)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg  <= tx_byte_next;
        tx_valid_reg <= tx_valid_next;
        finished_reg <= finished_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

endmodule

[design/uart_bootloader_host.sv]
`timescale 1ns / 1ps
// Host-side sequencer for a UART flash bootloader.
// Input channel (in_valid / in_stall): start items pick sync, erase, image
// write, go or unprotect; image bytes, received bytes and timeouts drive it on.
// Output channel (out_valid / out_stall): one item per transmit byte, plus one
// status item that ends each operation; last marks the final item of a burst.
// An input item may cause 0 to 5 output items.
// The first output item of an input passes through the command queue and
// then the output register. Throughput: one output item per cycle while
// out_stall is low; the front takes one input per cycle while its 4-entry
// command queue has room, so the output port sets the sustained rate.
// When the receiver stalls, the output register holds, the queue fills and
// in_stall rises once it is full.
// Reset clears the sequencer to idle, empties the queue and loads the
// default codes into the APB registers (byte offsets 0x00 to 0x1C).
module uart_bootloader_host (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [2:0]  operation,
    input  logic [31:0] start_address,
    input  logic [23:0] image_length,
    input  logic [7:0]  payload_byte,
    // Result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        finished,
    output logic [3:0]  status,
    output logic        last
);

    ubh_pkg::cfg_t  cfg_reg, cfg_next;
    ubh_pkg::desc_t push_desc;
    ubh_pkg::desc_t head_desc;
    logic           push;
    logic           pop;
    logic           queue_empty;
    logic           queue_full;
    logic           cfg_write;
    logic [2:0]     reg_index;

    assign pready    = 1'b1;
    assign in_stall  = queue_full;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                ubh_pkg::REG_ACK:       cfg_next.ack_code          = pwdata[7:0];
                ubh_pkg::REG_NACK:      cfg_next.nack_code         = pwdata[7:0];
                ubh_pkg::REG_SYNC:      cfg_next.sync_code         = pwdata[7:0];
                ubh_pkg::REG_WRITE:     cfg_next.write_command     = pwdata[7:0];
                ubh_pkg::REG_ERASE:     cfg_next.erase_command     = pwdata[7:0];
                ubh_pkg::REG_ERASE_ALL: cfg_next.erase_all_code    = pwdata[7:0];
                ubh_pkg::REG_GO:        cfg_next.go_command        = pwdata[7:0];
                default:                cfg_next.unprotect_command = pwdata[7:0];
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (reg_index)
            ubh_pkg::REG_ACK:       prdata = {24'b0, cfg_reg.ack_code};
            ubh_pkg::REG_NACK:      prdata = {24'b0, cfg_reg.nack_code};
            ubh_pkg::REG_SYNC:      prdata = {24'b0, cfg_reg.sync_code};
            ubh_pkg::REG_WRITE:     prdata = {24'b0, cfg_reg.write_command};
            ubh_pkg::REG_ERASE:     prdata = {24'b0, cfg_reg.erase_command};
            ubh_pkg::REG_ERASE_ALL: prdata = {24'b0, cfg_reg.erase_all_code};
            ubh_pkg::REG_GO:        prdata = {24'b0, cfg_reg.go_command};
            default:                prdata = {24'b0, cfg_reg.unprotect_command};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_code          <= 8'd121;
            cfg_reg.nack_code         <= 8'd31;
            cfg_reg.sync_code         <= 8'd127;
            cfg_reg.write_command     <= 8'd49;
            cfg_reg.erase_command     <= 8'd67;
            cfg_reg.erase_all_code    <= 8'd255;
            cfg_reg.go_command        <= 8'd33;
            cfg_reg.unprotect_command <= 8'd146;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ubh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .kind          (kind),
        .operation     (operation),
        .start_address (start_address),
        .image_length  (image_length),
        .payload_byte  (payload_byte),
        .queue_full    (queue_full),
        .push          (push),
        .push_desc     (push_desc)
    );

    ubh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    ubh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_desc   (head_desc),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .tx_valid    (tx_valid),
        .finished    (finished),
        .status      (status),
        .last        (last)
    );

endmodule
